FILE: hw/rtl/rfbp_pkg.sv
// Shared types, widths and codes for the framebuffer placer.
package rfbp_pkg;

	localparam int DIM_W   = 12;          // screen, image and pixel coordinates
	localparam int MODE_W  = 4;
	localparam int IDX_W   = 3;           // configuration register index
	localparam int PIX_W   = 24;
	localparam int ADDR_W  = 26;
	localparam int K_W     = DIM_W + 1;   // shrink factor, up to 4096
	localparam int RECIP_W = 25;          // floor(2^24 / k), k = 1 gives 2^24
	localparam int DEST_W  = DIM_W + 1;   // destination coordinate before clipping

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4095);
	localparam logic [RECIP_W-1:0] RECIP_ONE = {1'b1, {(RECIP_W-1){1'b0}}};

	// Placement modes
	localparam logic [MODE_W-1:0] MODE_FIT       = 4'd1;
	localparam logic [MODE_W-1:0] MODE_ROW_BLIND = 4'd6;
	localparam logic [MODE_W-1:0] MODE_COL_BLIND = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ORIGIN    = 4'd8;

	// Register indexes on the write port
	localparam logic [IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
	localparam logic [IDX_W-1:0] REG_ORIGIN_COL    = 3'd5;
	localparam logic [IDX_W-1:0] REG_ORIGIN_ROW    = 3'd6;

	// Result status codes
	localparam logic [1:0] STATUS_WRITTEN     = 2'd0;
	localparam logic [1:0] STATUS_SKIPPED     = 2'd1;
	localparam logic [1:0] STATUS_CLIPPED     = 2'd2;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0] src_row;
		logic [DIM_W-1:0] src_col;
		logic [PIX_W-1:0] pixel_bytes;
	} pixel_req_t;

	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] fb_byte_address;
		logic [PIX_W-1:0]  pixel_word;
		logic [1:0]        status;
	} place_result_t;

	// Register contents and the values derived from them, setup to pipeline
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [DIM_W-1:0]   origin_col;
		logic [DIM_W-1:0]   origin_row;
		logic               dims_ok;
		logic               oversized;
		logic [K_W-1:0]     k;
		logic [RECIP_W-1:0] recip;
		logic [DIM_W-1:0]   off_row;
		logic [DIM_W-1:0]   off_col;
	} place_cfg_t;

	typedef enum logic [3:0] {
		SU_RH_GO,
		SU_RH_WAIT,
		SU_RW_GO,
		SU_RW_WAIT,
		SU_RC_GO,
		SU_RC_WAIT,
		SU_SHH_GO,
		SU_SHH_WAIT,
		SU_SHW_GO,
		SU_SHW_WAIT,
		SU_FINISH,
		SU_READY
	} setup_state_t;

endpackage

FILE: hw/rtl/rfbp_div.sv
// Restoring divider, one quotient bit per cycle, for the setup sequencer.
module rfbp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [rfbp_pkg::RECIP_W-1:0] dividend,
	input  logic [rfbp_pkg::K_W-1:0]     divisor,
	output logic                        done,
	output logic [rfbp_pkg::RECIP_W-1:0] quotient
);

	localparam int STEPS = rfbp_pkg::RECIP_W;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int QW    = rfbp_pkg::RECIP_W;
	localparam int DW    = rfbp_pkg::K_W;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    quo_q;
	logic [DW-1:0]    dsr_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             fits;

	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !go && (cnt_q == CNT_W'(1));
			if (go) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/rfbp_setup.sv
// Configuration registers and the sequencer that derives the shrink factor and offsets.
module rfbp_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rfbp_pkg::IDX_W-1:0]    wr_index,
	input  logic [rfbp_pkg::DIM_W-1:0]    wr_data,
	output logic                          ready,
	output rfbp_pkg::place_cfg_t          cfg
);

	localparam int DW = rfbp_pkg::DIM_W;
	localparam int KW = rfbp_pkg::K_W;
	localparam int RW = rfbp_pkg::RECIP_W;

	rfbp_pkg::setup_state_t state_q, state_d;

	logic [rfbp_pkg::MODE_W-1:0] mode_q;
	logic [DW-1:0] screen_width_q, screen_height_q, image_width_q, image_height_q;
	logic [DW-1:0] origin_col_q, origin_row_q;

	logic [DW-1:0] rh_q, shh_q, shw_q;
	logic [KW-1:0] k_q;
	logic [RW-1:0] recip_q;
	logic          dims_ok_q, oversized_q;
	logic [DW-1:0] off_row_q, off_col_q;

	logic          div_go, div_done;
	logic [RW-1:0] div_dividend, div_quo;
	logic [KW-1:0] div_divisor;
	logic [DW-1:0] rw_new;
	logic          dims_ok_c, oversized_c;

	rfbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state: any register write restarts the whole derivation
	always_comb begin
		state_d = state_q;
		if (wr_en) begin
			state_d = rfbp_pkg::SU_RH_GO;
		end else begin
			case (state_q)
				rfbp_pkg::SU_RH_GO:    state_d = rfbp_pkg::SU_RH_WAIT;
				rfbp_pkg::SU_RH_WAIT:  if (div_done) state_d = rfbp_pkg::SU_RW_GO;
				rfbp_pkg::SU_RW_GO:    state_d = rfbp_pkg::SU_RW_WAIT;
				rfbp_pkg::SU_RW_WAIT:  if (div_done) state_d = rfbp_pkg::SU_RC_GO;
				rfbp_pkg::SU_RC_GO:    state_d = rfbp_pkg::SU_RC_WAIT;
				rfbp_pkg::SU_RC_WAIT:  if (div_done) state_d = rfbp_pkg::SU_SHH_GO;
				rfbp_pkg::SU_SHH_GO:   state_d = rfbp_pkg::SU_SHH_WAIT;
				rfbp_pkg::SU_SHH_WAIT: if (div_done) state_d = rfbp_pkg::SU_SHW_GO;
				rfbp_pkg::SU_SHW_GO:   state_d = rfbp_pkg::SU_SHW_WAIT;
				rfbp_pkg::SU_SHW_WAIT: if (div_done) state_d = rfbp_pkg::SU_FINISH;
				rfbp_pkg::SU_FINISH:   state_d = rfbp_pkg::SU_READY;
				rfbp_pkg::SU_READY:    state_d = rfbp_pkg::SU_READY;
				default:               state_d = rfbp_pkg::SU_RH_GO;
			endcase
		end
	end

	// Outputs: divider launch and operand selection
	always_comb begin
		div_go       = 1'b0;
		div_dividend = RW'(image_height_q);
		div_divisor  = KW'(screen_height_q);
		case (state_q)
			rfbp_pkg::SU_RH_GO: begin
				div_go = 1'b1;
			end
			rfbp_pkg::SU_RW_GO: begin
				div_go       = 1'b1;
				div_dividend = RW'(image_width_q);
				div_divisor  = KW'(screen_width_q);
			end
			rfbp_pkg::SU_RC_GO: begin
				div_go       = 1'b1;
				div_dividend = rfbp_pkg::RECIP_ONE;
				div_divisor  = k_q;
			end
			rfbp_pkg::SU_SHH_GO: begin
				div_go       = 1'b1;
				div_divisor  = k_q;
			end
			rfbp_pkg::SU_SHW_GO: begin
				div_go       = 1'b1;
				div_dividend = RW'(image_width_q);
				div_divisor  = k_q;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	assign ready = (state_q == rfbp_pkg::SU_READY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= rfbp_pkg::SU_RH_GO;
			mode_q          <= rfbp_pkg::MODE_FIT;
			screen_width_q  <= DW'(800);
			screen_height_q <= DW'(480);
			image_width_q   <= DW'(800);
			image_height_q  <= DW'(480);
			origin_col_q    <= '0;
			origin_row_q    <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					rfbp_pkg::REG_MODE:          mode_q <= wr_data[rfbp_pkg::MODE_W-1:0];
					rfbp_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= wr_data;
					rfbp_pkg::REG_SCREEN_HEIGHT: screen_height_q <= wr_data;
					rfbp_pkg::REG_IMAGE_WIDTH:   image_width_q   <= wr_data;
					rfbp_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= wr_data;
					rfbp_pkg::REG_ORIGIN_COL:    origin_col_q    <= wr_data;
					rfbp_pkg::REG_ORIGIN_ROW:    origin_row_q    <= wr_data;
					default: ;
				endcase
			end
		end
	end

	assign rw_new = div_quo[DW-1:0];

	assign dims_ok_c = (screen_width_q != '0) && (screen_width_q <= rfbp_pkg::MAX_DIM) &&
		(screen_height_q != '0) && (screen_height_q <= rfbp_pkg::MAX_DIM) &&
		(image_width_q != '0) && (image_width_q <= rfbp_pkg::MAX_DIM) &&
		(image_height_q != '0) && (image_height_q <= rfbp_pkg::MAX_DIM);
	assign oversized_c = (image_width_q > screen_width_q) ||
		(image_height_q > screen_height_q);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (state_q)
				rfbp_pkg::SU_RH_WAIT: rh_q <= div_quo[DW-1:0];
				rfbp_pkg::SU_RW_WAIT: begin
					if (oversized_c) begin
						k_q <= (rh_q > rw_new) ? (KW'(rh_q) + KW'(1)) : (KW'(rw_new) + KW'(1));
					end else begin
						k_q <= KW'(1);	// no shrink: every pixel is on the grid
					end
				end
				rfbp_pkg::SU_RC_WAIT:  recip_q <= div_quo;
				rfbp_pkg::SU_SHH_WAIT: shh_q   <= div_quo[DW-1:0];
				rfbp_pkg::SU_SHW_WAIT: shw_q   <= div_quo[DW-1:0];
				default: ;
			endcase
		end
		if (state_q == rfbp_pkg::SU_FINISH) begin
			dims_ok_q   <= dims_ok_c;
			oversized_q <= oversized_c;
			if (oversized_c) begin
				off_row_q <= (screen_height_q - shh_q) >> 1;
				off_col_q <= (screen_width_q - shw_q) >> 1;
			end else begin
				off_row_q <= (screen_height_q - image_height_q) >> 1;
				off_col_q <= (screen_width_q - image_width_q) >> 1;
			end
		end
	end

	always_comb begin
		cfg.mode          = mode_q;
		cfg.screen_width  = screen_width_q;
		cfg.screen_height = screen_height_q;
		cfg.image_width   = image_width_q;
		cfg.image_height  = image_height_q;
		cfg.origin_col    = origin_col_q;
		cfg.origin_row    = origin_row_q;
		cfg.dims_ok       = dims_ok_q;
		cfg.oversized     = oversized_q;
		cfg.k             = k_q;
		cfg.recip         = recip_q;
		cfg.off_row       = off_row_q;
		cfg.off_col       = off_col_q;
	end

endmodule

FILE: hw/rtl/rfbp_pipe.sv
// Five-stage placement pipeline: checks, shrink sampling, destination, address.
module rfbp_pipe (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  rfbp_pkg::pixel_req_t    in_req,
	input  rfbp_pkg::place_cfg_t    cfg,
	output logic                    out_valid,
	output rfbp_pkg::place_result_t out_result
);

	localparam int DW = rfbp_pkg::DIM_W;
	localparam int KW = rfbp_pkg::K_W;
	localparam int RW = rfbp_pkg::RECIP_W;
	localparam int EW = rfbp_pkg::DEST_W;
	localparam int PW = rfbp_pkg::PIX_W;
	localparam int AW = rfbp_pkg::ADDR_W;

	// Stage 1: early status and estimated quotients
	logic          unsup, clip_early;
	logic [DW+RW-1:0] prod_r, prod_c;
	logic          v_s1;
	logic [1:0]    status_s1;
	logic [DW-1:0] row_s1, col_s1, q0r_s1, q0c_s1;
	logic [PW-1:0] pix_s1;

	assign unsup = (cfg.mode < rfbp_pkg::MODE_FIT) || (cfg.mode > rfbp_pkg::MODE_ORIGIN) ||
		!cfg.dims_ok ||
		(cfg.oversized && cfg.mode != rfbp_pkg::MODE_FIT &&
		cfg.mode != rfbp_pkg::MODE_COL_BLIND);
	assign clip_early = (in_req.src_row >= cfg.image_height) ||
		(in_req.src_col >= cfg.image_width) ||
		(cfg.mode == rfbp_pkg::MODE_ROW_BLIND &&
		in_req.src_row >= {cfg.image_height[DW-1:2], 2'b00}) ||
		(cfg.mode == rfbp_pkg::MODE_COL_BLIND &&
		in_req.src_col >= {cfg.image_width[DW-1:2], 2'b00});
	assign prod_r = (DW+RW)'(in_req.src_row) * (DW+RW)'(cfg.recip);
	assign prod_c = (DW+RW)'(in_req.src_col) * (DW+RW)'(cfg.recip);

	// Stage 2: remainder of the estimate
	logic [DW+KW-1:0] qk_r, qk_c;
	logic          v_s2;
	logic [1:0]    status_s2;
	logic [DW-1:0] row_s2, col_s2, q0r_s2, q0c_s2, remr_s2, remc_s2;
	logic [PW-1:0] pix_s2;

	assign qk_r = (DW+KW)'(q0r_s1) * (DW+KW)'(cfg.k);
	assign qk_c = (DW+KW)'(q0c_s1) * (DW+KW)'(cfg.k);

	// Stage 3: correct the quotient, sample, destination
	logic          corr_r, corr_c, skip;
	logic [DW-1:0] qr, qc, remr_fix, remc_fix, base_r, base_c, offs_r, offs_c;
	logic          v_s3;
	logic [1:0]    status_s3;
	logic [EW-1:0] drow_s3, dcol_s3;
	logic [PW-1:0] pix_s3;

	assign corr_r   = {1'b0, remr_s2} >= cfg.k;
	assign corr_c   = {1'b0, remc_s2} >= cfg.k;
	assign remr_fix = corr_r ? (remr_s2 - cfg.k[DW-1:0]) : remr_s2;
	assign remc_fix = corr_c ? (remc_s2 - cfg.k[DW-1:0]) : remc_s2;
	assign qr       = q0r_s2 + DW'(corr_r);
	assign qc       = q0c_s2 + DW'(corr_c);
	assign skip     = (remr_fix != '0) || (remc_fix != '0);
	assign base_r   = (cfg.mode == rfbp_pkg::MODE_ORIGIN) ? row_s2 : qr;
	assign base_c   = (cfg.mode == rfbp_pkg::MODE_ORIGIN) ? col_s2 : qc;
	assign offs_r   = (cfg.mode == rfbp_pkg::MODE_ORIGIN) ? cfg.origin_row : cfg.off_row;
	assign offs_c   = (cfg.mode == rfbp_pkg::MODE_ORIGIN) ? cfg.origin_col : cfg.off_col;

	// Stage 4: screen clipping and row base
	logic          off_screen;
	logic          v_s4;
	logic [1:0]    status_s4;
	logic [2*DW-1:0] rowbase_s4;
	logic [DW-1:0] dcol_s4;
	logic [PW-1:0] pix_s4;

	assign off_screen = (drow_s3 >= EW'(cfg.screen_height)) ||
		(dcol_s3 >= EW'(cfg.screen_width));

	// Output stage
	logic [2*DW-1:0]        pix_index;
	logic                   done_q;
	rfbp_pkg::place_result_t result_q;

	assign pix_index = rowbase_s4 + (2*DW)'(dcol_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		row_s1 <= in_req.src_row;
		col_s1 <= in_req.src_col;
		pix_s1 <= in_req.pixel_bytes;
		q0r_s1 <= prod_r[RW-1 +: DW];
		q0c_s1 <= prod_c[RW-1 +: DW];
		if (unsup) begin
			status_s1 <= rfbp_pkg::STATUS_UNSUPPORTED;
		end else if (clip_early) begin
			status_s1 <= rfbp_pkg::STATUS_CLIPPED;
		end else begin
			status_s1 <= rfbp_pkg::STATUS_WRITTEN;
		end

		// stage 2
		status_s2 <= status_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		pix_s2    <= pix_s1;
		q0r_s2    <= q0r_s1;
		q0c_s2    <= q0c_s1;
		remr_s2   <= row_s1 - qk_r[DW-1:0];
		remc_s2   <= col_s1 - qk_c[DW-1:0];

		// stage 3: drop pixels off the sampling grid
		pix_s3  <= pix_s2;
		drow_s3 <= EW'(base_r) + EW'(offs_r);
		dcol_s3 <= EW'(base_c) + EW'(offs_c);
		if (status_s2 == rfbp_pkg::STATUS_WRITTEN && skip) begin
			status_s3 <= rfbp_pkg::STATUS_SKIPPED;
		end else begin
			status_s3 <= status_s2;
		end

		// stage 4
		pix_s4     <= pix_s3;
		dcol_s4    <= dcol_s3[DW-1:0];
		rowbase_s4 <= (2*DW)'(drow_s3[DW-1:0]) * (2*DW)'(cfg.screen_width);
		if (status_s3 == rfbp_pkg::STATUS_WRITTEN && off_screen) begin
			status_s4 <= rfbp_pkg::STATUS_CLIPPED;
		end else begin
			status_s4 <= status_s3;
		end

		// output: zero everything but the status when nothing is written
		result_q.status <= status_s4;
		if (status_s4 == rfbp_pkg::STATUS_WRITTEN) begin
			result_q.write_valid     <= 1'b1;
			result_q.fb_byte_address <= {pix_index[AW-3:0], 2'b00};
			result_q.pixel_word      <= pix_s4;
		end else begin
			result_q.write_valid     <= 1'b0;
			result_q.fb_byte_address <= '0;
			result_q.pixel_word      <= '0;
		end
	end

	assign out_valid  = done_q;
	assign out_result = result_q;

endmodule

FILE: hw/rtl/rgb_to_framebuffer_placer_core.sv
// Top level of the framebuffer placer: register port, setup sequencer and pipeline.
//
// Takes one source pixel per clock while busy is low and returns, for each request
// taken, one result: the framebuffer byte address (four bytes per pixel), the
// 24-bit colour word, and a status (written, skipped by shrink sampling, clipped
// or off screen, unsupported size or mode). Results appear on result for exactly
// one cycle with done high; the receiver cannot stall them, so a request taken on
// every cycle gives a result on every cycle. A request is taken when start is high
// and busy is low. After reset and after every register write, busy stays high
// while the sequencer runs a one-bit-per-cycle divider to work out the shrink
// factor, its reciprocal and the shrunk image size (five divisions), then the
// centring offsets; register writes are taken at any time and restart that
// sequence. Write the registers only when no request is in flight.
module rgb_to_framebuffer_placer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rfbp_pkg::pixel_req_t          req,
	output logic                          done,
	output rfbp_pkg::place_result_t       result,
	input  logic                          wr_en,
	input  logic [rfbp_pkg::IDX_W-1:0]    wr_index,
	input  logic [rfbp_pkg::DIM_W-1:0]    wr_data
);

	logic                 ready;
	logic                 accept;
	rfbp_pkg::place_cfg_t cfg;

	// Hold requests off while the derived values are being rebuilt
	assign busy   = !ready;
	assign accept = start && ready;

	rfbp_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.ready    (ready),
		.cfg      (cfg)
	);

	// Advance one pixel per cycle; valid bits travel with the data
	rfbp_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_req     (req),
		.cfg        (cfg),
		.out_valid  (done),
		.out_result (result)
	);

endmodule

FILE: tb/sv/rfbp_placement_checker.sv
// Placement checker: tracks register writes, predicts each placement and compares results.
module rfbp_placement_checker
	import rfbp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  pixel_req_t                req,
	input  logic                      done,
	input  place_result_t             result,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_index,
	input  logic [DIM_W-1:0]          wr_data,
	output int                        fail_count,
	output int                        outstanding
);

	localparam int unsigned BLIND_STEP      = 4;
	localparam int unsigned BYTES_PER_PIXEL = 4;

	localparam logic [DIM_W-1:0] RESET_SCREEN_W = DIM_W'(800);
	localparam logic [DIM_W-1:0] RESET_SCREEN_H = DIM_W'(480);

	logic [MODE_W-1:0] cfg_mode;
	logic [DIM_W-1:0]  cfg_screen_w;
	logic [DIM_W-1:0]  cfg_screen_h;
	logic [DIM_W-1:0]  cfg_image_w;
	logic [DIM_W-1:0]  cfg_image_h;
	logic [DIM_W-1:0]  cfg_origin_col;
	logic [DIM_W-1:0]  cfg_origin_row;

	place_result_t placements_due[$];

	function automatic bit dim_usable(input int unsigned d);
		return d != 0 && d <= MAX_DIM;
	endfunction

	function automatic place_result_t place_pixel(input pixel_req_t p);
		int unsigned   row, col, sw, sh, iw, ih, drow, dcol, rh, rw, k;
		logic [1:0]    st;
		bit            oversized;
		place_result_t r;
		row  = p.src_row;
		col  = p.src_col;
		sw   = cfg_screen_w;
		sh   = cfg_screen_h;
		iw   = cfg_image_w;
		ih   = cfg_image_h;
		drow = 0;
		dcol = 0;
		st   = STATUS_WRITTEN;
		oversized = (iw > sw) || (ih > sh);
		if (cfg_mode < MODE_FIT || cfg_mode > MODE_ORIGIN)
			st = STATUS_UNSUPPORTED;
		else if (!dim_usable(sw) || !dim_usable(sh) || !dim_usable(iw) || !dim_usable(ih))
			st = STATUS_UNSUPPORTED;
		else if (oversized && cfg_mode != MODE_FIT && cfg_mode != MODE_COL_BLIND)
			st = STATUS_UNSUPPORTED;
		else if (row >= ih || col >= iw)
			st = STATUS_CLIPPED;
		else if (cfg_mode == MODE_ROW_BLIND && row >= BLIND_STEP * (ih / BLIND_STEP))
			st = STATUS_CLIPPED;
		else if (cfg_mode == MODE_COL_BLIND && col >= BLIND_STEP * (iw / BLIND_STEP))
			st = STATUS_CLIPPED;
		else if (cfg_mode == MODE_ORIGIN) begin
			drow = row + cfg_origin_row;
			dcol = col + cfg_origin_col;
		end else if (oversized) begin
			rh = ih / sh;
			rw = iw / sw;
			k  = ((rh > rw) ? rh : rw) + 1;
			if (row % k != 0 || col % k != 0)
				st = STATUS_SKIPPED;
			drow = row / k + (sh - ih / k) / 2;
			dcol = col / k + (sw - iw / k) / 2;
		end else begin
			drow = row + (sh - ih) / 2;
			dcol = col + (sw - iw) / 2;
		end
		if (st == STATUS_WRITTEN && (drow >= sh || dcol >= sw))
			st = STATUS_CLIPPED;
		r.write_valid     = (st == STATUS_WRITTEN);
		r.fb_byte_address = (st == STATUS_WRITTEN) ?
			ADDR_W'((drow * sw + dcol) * BYTES_PER_PIXEL) : '0;
		r.pixel_word      = (st == STATUS_WRITTEN) ? p.pixel_bytes : '0;
		r.status          = st;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		place_result_t want;
		if (!arst_n) begin
			cfg_mode       = MODE_FIT;
			cfg_screen_w   = RESET_SCREEN_W;
			cfg_screen_h   = RESET_SCREEN_H;
			cfg_image_w    = RESET_SCREEN_W;
			cfg_image_h    = RESET_SCREEN_H;
			cfg_origin_col = '0;
			cfg_origin_row = '0;
			placements_due.delete();
			fail_count     = 0;
			outstanding    = 0;
		end else begin
			if (done) begin
				if (placements_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result valid %0b addr %0d word %h status %0d",
						$time, result.write_valid, result.fb_byte_address,
						result.pixel_word, result.status);
				end else begin
					want = placements_due.pop_front();
					if (result.write_valid !== want.write_valid ||
					    result.fb_byte_address !== want.fb_byte_address ||
					    result.pixel_word !== want.pixel_word ||
					    result.status !== want.status) begin
						fail_count++;
						$display("%0t: expected valid %0b addr %0d word %h status %0d, got valid %0b addr %0d word %h status %0d",
							$time, want.write_valid, want.fb_byte_address, want.pixel_word,
							want.status, result.write_valid, result.fb_byte_address,
							result.pixel_word, result.status);
					end
				end
			end
			if (start && !busy)
				placements_due.push_back(place_pixel(req));
			if (wr_en) begin
				case (wr_index)
					REG_MODE:          cfg_mode       = wr_data[MODE_W-1:0];
					REG_SCREEN_WIDTH:  cfg_screen_w   = wr_data;
					REG_SCREEN_HEIGHT: cfg_screen_h   = wr_data;
					REG_IMAGE_WIDTH:   cfg_image_w    = wr_data;
					REG_IMAGE_HEIGHT:  cfg_image_h    = wr_data;
					REG_ORIGIN_COL:    cfg_origin_col = wr_data;
					REG_ORIGIN_ROW:    cfg_origin_row = wr_data;
					default: ;
				endcase
			end
			outstanding = placements_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_rgb_to_framebuffer_placer_core.sv
// Testbench top for the framebuffer placer: clock, reset, request stimulus and verdict.
module tb_rgb_to_framebuffer_placer_core;
	import rfbp_pkg::*;

	// Modes without a name in the package: the plain centred ones and two unknown codes
	localparam logic [MODE_W-1:0] MODE_UNKNOWN_LOW  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_CENTRE_2     = 4'd2;
	localparam logic [MODE_W-1:0] MODE_CENTRE_3     = 4'd3;
	localparam logic [MODE_W-1:0] MODE_CENTRE_4     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_CENTRE_5     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_UNKNOWN_HIGH = 4'd15;

	localparam int unsigned MAX_SRC        = 4094;   // largest source coordinate sent
	localparam int unsigned RANDOM_PHASES  = 14;
	localparam int unsigned PHASE_REQUESTS = 124;
	localparam int unsigned THIRD          = 587;    // a third of all requests, roughly
	localparam int unsigned DRAIN_CYCLES   = 12;     // pipeline is five deep
	localparam int unsigned CYCLE_LIMIT    = 400000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	pixel_req_t          req       = '0;
	logic                done;
	place_result_t       result;
	logic                wr_en     = 1'b0;
	logic [IDX_W-1:0]    wr_index  = REG_MODE;
	logic [DIM_W-1:0]    wr_data   = '0;
	int                  failures;
	int                  pending_results;
	int unsigned         requests_sent = 0;
	int unsigned         cycle_count   = 0;

	// Local copy of the image and screen sizes, used only to shape the stimulus
	logic [DIM_W-1:0]    scr_w, scr_h, img_w, img_h;

	rgb_to_framebuffer_placer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	rfbp_placement_checker placement_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.result      (result),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.fail_count  (failures),
		.outstanding (pending_results)
	);

	always #1 clk = ~clk;

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. The sender idles
	// 31 times in a hundred over the first third, 49 over the second and never after.
	task automatic send_pixel(input int unsigned row, input int unsigned col,
			input logic [PIX_W-1:0] bytes);
		int unsigned idle_pct;
		idle_pct = (requests_sent < THIRD) ? 31 : (requests_sent < 2 * THIRD) ? 49 : 0;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start           <= 1'b1;
		req.src_row     <= DIM_W'(row);
		req.src_col     <= DIM_W'(col);
		req.pixel_bytes <= bytes;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// Drop start, let every result drain, then write all seven registers back to back.
	// Each request yields a result, so an empty expectation queue means the block is idle.
	task automatic configure(input logic [MODE_W-1:0] mode,
			input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
			input logic [DIM_W-1:0] iw, input logic [DIM_W-1:0] ih,
			input logic [DIM_W-1:0] oc, input logic [DIM_W-1:0] orow);
		logic [DIM_W-1:0] reg_value [2**IDX_W];
		@(negedge clk);
		start <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		// upper bits of the mode write are junk and must be ignored
		reg_value[REG_MODE]          = {DIM_W'($urandom_range(255)) << MODE_W} | DIM_W'(mode);
		reg_value[REG_SCREEN_WIDTH]  = sw;
		reg_value[REG_SCREEN_HEIGHT] = sh;
		reg_value[REG_IMAGE_WIDTH]   = iw;
		reg_value[REG_IMAGE_HEIGHT]  = ih;
		reg_value[REG_ORIGIN_COL]    = oc;
		reg_value[REG_ORIGIN_ROW]    = orow;
		for (int i = REG_MODE; i <= REG_ORIGIN_ROW; i++) begin
			wr_en    <= 1'b1;
			wr_index <= IDX_W'(i);
			wr_data  <= reg_value[i];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		scr_w = sw;
		scr_h = sh;
		img_w = iw;
		img_h = ih;
	endtask

	// Screen size: mostly small, with zero and the maximum now and then
	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 3)
			return '0;
		if (sel < 8)
			return MAX_DIM;
		if (sel < 45)
			return DIM_W'($urandom_range(16, 1));
		if (sel < 80)
			return DIM_W'($urandom_range(300, 1));
		return DIM_W'($urandom_range(MAX_DIM, 1));
	endfunction

	// Image size relative to the screen: grown past it to force a shrink, or within it
	function automatic logic [DIM_W-1:0] pick_image_dim(input logic [DIM_W-1:0] screen_dim,
			input bit oversize);
		int unsigned d;
		if (screen_dim == 0 || $urandom_range(99) < 15)
			return pick_dim();
		if (oversize)
			d = screen_dim + $urandom_range(3 * screen_dim);
		else
			d = $urandom_range(screen_dim, 1);
		return (d > MAX_DIM) ? MAX_DIM : DIM_W'(d);
	endfunction

	// Source coordinate: mostly inside the image, often on the shrink grid,
	// sometimes on the last line or just past it, and now and then anywhere
	function automatic int unsigned pick_coord(input int unsigned extent, input int unsigned step);
		int unsigned sel;
		sel = $urandom_range(99);
		if (extent == 0 || sel < 12)
			return $urandom_range(MAX_SRC);
		if (sel < 18)
			return (extent > MAX_SRC) ? MAX_SRC : extent - $urandom_range(1);
		if (step > 1 && sel < 60)
			return step * $urandom_range((extent - 1) / step);
		return $urandom_range(extent - 1);
	endfunction

	initial begin : stimulus
		logic [MODE_W-1:0] mode_pick;
		logic [DIM_W-1:0]  sw, sh, iw, ih, oc, orow;
		int unsigned       rh, rw, step;
		bit                oversize;

		// Hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: 800x480 image centred on an 800x480 screen
		send_pixel(0, 0, 24'h000000);
		send_pixel(479, 799, 24'hFFFFFF);
		send_pixel(480, 5, 24'h123456);            // row outside the image
		send_pixel(7, 800, 24'h654321);            // column outside the image
		send_pixel(MAX_SRC, MAX_SRC, 24'hA5A5A5);

		// Origin mode on the largest screen: the highest byte address
		configure(MODE_ORIGIN, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, '0, '0);
		send_pixel(MAX_SRC, MAX_SRC, 24'hFFFFFF);
		send_pixel(0, 0, 24'h800001);
		// Origin pushed to the far corner: off screen
		configure(MODE_ORIGIN, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
		send_pixel(0, 0, 24'h5A5A5A);

		// Shrink by eleven: grid pixels land, the rest are skipped
		configure(MODE_FIT, 100, 50, 1000, 400, '0, '0);
		send_pixel(0, 0, 24'h010203);
		send_pixel(11, 22, 24'h0A0B0C);
		send_pixel(1, 0, 24'hFEDCBA);
		send_pixel(0, 5, 24'h00FF00);

		// Column blinds with the largest shrink onto a one-pixel screen
		configure(MODE_COL_BLIND, 1, 1, MAX_DIM, MAX_DIM, '0, '0);
		send_pixel(0, 0, 24'hC0FFEE);
		send_pixel(0, 4092, 24'h111111);           // past the last whole group of four
		send_pixel(MAX_SRC, 0, 24'h222222);

		// Row blinds: only the first four of seven rows are drawn
		configure(MODE_ROW_BLIND, 10, 10, 10, 7, '0, '0);
		send_pixel(3, 9, 24'h333333);
		send_pixel(4, 0, 24'h444444);

		// Unsupported cases: oversized image in a centred mode, unknown modes, zero width
		configure(MODE_CENTRE_3, 10, 10, 11, 10, '0, '0);
		send_pixel(0, 0, 24'h555555);
		configure(MODE_UNKNOWN_LOW, 800, 480, 800, 480, '0, '0);
		send_pixel(0, 0, 24'h666666);
		configure(MODE_UNKNOWN_HIGH, 800, 480, 800, 480, '0, '0);
		send_pixel(0, 0, 24'h777777);
		configure(MODE_CENTRE_2, '0, 480, 800, 480, '0, '0);
		send_pixel(0, 0, 24'h888888);

		// Smallest screen and image, then a small image centred on a larger screen
		configure(MODE_CENTRE_5, 1, 1, 1, 1, '0, '0);
		send_pixel(0, 0, 24'h999999);
		configure(MODE_CENTRE_4, 20, 20, 9, 7, '0, '0);
		send_pixel(0, 0, 24'hAAAAAA);
		send_pixel(6, 8, 24'hBBBBBB);

		// Random settings, each followed by a burst of requests shaped for them
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if ($urandom_range(9) == 0)
				mode_pick = $urandom_range(1) ? MODE_UNKNOWN_LOW :
					MODE_W'($urandom_range(MODE_UNKNOWN_HIGH, MODE_ORIGIN + 1));
			else
				mode_pick = MODE_W'($urandom_range(MODE_ORIGIN, MODE_FIT));
			oversize = (mode_pick == MODE_FIT || mode_pick == MODE_COL_BLIND) &&
				$urandom_range(1);
			sw = pick_dim();
			sh = pick_dim();
			iw = pick_image_dim(sw, oversize);
			ih = pick_image_dim(sh, oversize);
			oc = ($urandom_range(99) < 25) ? DIM_W'($urandom_range(MAX_DIM)) :
				DIM_W'($urandom_range(sw));
			orow = ($urandom_range(99) < 25) ? DIM_W'($urandom_range(MAX_DIM)) :
				DIM_W'($urandom_range(sh));
			configure(mode_pick, sw, sh, iw, ih, oc, orow);

			// Aim at the shrink grid when the image is oversized
			step = 1;
			if (scr_w != 0 && scr_h != 0 && (img_w > scr_w || img_h > scr_h)) begin
				rh = img_h / scr_h;
				rw = img_w / scr_w;
				step = ((rh > rw) ? rh : rw) + 1;
			end
			for (int n = 0; n < PHASE_REQUESTS; n++)
				send_pixel(pick_coord(img_h, step), pick_coord(img_w, step), PIX_W'($urandom));
		end

		// Drain, allow for the pipeline, then give the verdict
		@(negedge clk);
		start <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
